@@ rtl/core/shtlp_pkg.sv @@
// Package for the linear-probe symbol hash table.
// Holds the table size, status codes and the item, slot and guard types.
// No dependencies.
package shtlp_pkg;

  localparam int SLOTS = 1024;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int HALF = SLOTS / 2;

  localparam logic [1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [1:0] STATUS_FOUND     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_REFUSED   = 2'd3;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] key_hash;
    logic [31:0] name_id;
    logic [7:0]  first_char;
    logic [15:0] name_length;
    logic [31:0] symbol_handle;
  } item_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] name;
    logic [31:0] symbol;
  } slot_t;

  typedef struct packed {
    logic find_reject;
    logic insert_refuse;
  } guard_t;

endpackage

@@ rtl/core/shtlp_if.sv @@
// Channel interfaces of the symbol hash table: request words in, result words out.
// Depends on nothing outside this file.
interface shtlp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] key_hash;
  logic [31:0] name_id;
  logic [7:0]  first_char;
  logic [15:0] name_length;
  logic [31:0] symbol_handle;

  modport source (output valid, operation, key_hash, name_id, first_char, name_length,
                  symbol_handle, input ready);
  modport sink (input valid, operation, key_hash, name_id, first_char, name_length,
                symbol_handle, output ready);
endinterface

interface shtlp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_handle;

  modport source (output valid, status, found_handle, input ready);
  modport sink (input valid, status, found_handle, output ready);
endinterface

@@ rtl/core/symbol_hash_table_linear_probe.sv @@
// Top level of the open-addressed symbol table with linear probing.
// Depends on shtlp_pkg, shtlp_if and shtlp_guard.
//
//   channel  | dir | handshake     | word
//   in_ch    | in  | valid/ready   | operation, key_hash, name_id, first_char,
//            |     |               | name_length, symbol_handle
//   out_ch   | out | valid/ready   | status, found_handle
//
// An item is accepted, then probes slot after slot from its hash index, then hands its
// result to out_ch; the probe is bound by the single read port of the slot memory.
// Early rejections and refusals skip the probe.
// After reset a clearing pass empties all SLOTS (1024) slots; in_ch is not ready meanwhile.
// The next word is accepted while a result still waits on a stalled out_ch.
module symbol_hash_table_linear_probe (
  input logic            clk,
  input logic            rst_n,
  shtlp_in_if.sink       in_ch,
  shtlp_out_if.source    out_ch
);
  import shtlp_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  slot_t mem [SLOTS];
  slot_t rd_q_r;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  item_t            item_r, item_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [31:0]      res_handle_r, res_handle_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [31:0]      out_handle_r, out_handle_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic             upd_en;
  logic             accept;
  item_t            in_item;
  guard_t           guard;
  logic             slot_empty;
  logic             slot_match;

  assign in_item = '{operation: in_ch.operation, key_hash: in_ch.key_hash,
                     name_id: in_ch.name_id, first_char: in_ch.first_char,
                     name_length: in_ch.name_length, symbol_handle: in_ch.symbol_handle};

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign accept          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.found_handle = out_handle_r;

  assign slot_empty = (rd_q_r.hash == 32'd0);
  assign slot_match = (rd_q_r.hash == item_r.key_hash) && (rd_q_r.name == item_r.name_id);

  shtlp_guard u_guard (
    .clk      (clk),
    .rst_n    (rst_n),
    .chk_item (in_item),
    .upd_item (item_r),
    .upd_en   (upd_en),
    .guard    (guard)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    item_nxt       = item_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '{hash: item_r.key_hash, name: item_r.name_id,
                       symbol: item_r.symbol_handle};
    upd_en         = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = '0;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_nxt       = in_item;
          res_handle_nxt = '0;
          idx_nxt        = in_item.key_hash[IDX_W-1:0];
          cnt_nxt        = '0;
          if (in_item.operation == OP_INSERT && guard.insert_refuse) begin
            res_status_nxt = STATUS_REFUSED;
            state_nxt      = ST_DONE;
          end else if (in_item.operation == OP_FIND && guard.find_reject) begin
            res_status_nxt = STATUS_NOT_FOUND;
            state_nxt      = ST_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = in_item.key_hash[IDX_W-1:0];
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (slot_empty) begin
          state_nxt = ST_DONE;
          if (item_r.operation == OP_INSERT) begin
            wr_en          = 1'b1;
            upd_en         = 1'b1;
            res_status_nxt = STATUS_INSERTED;
          end else begin
            res_status_nxt = STATUS_NOT_FOUND;
          end
        end else if (item_r.operation == OP_FIND && slot_match) begin
          res_status_nxt = STATUS_FOUND;
          res_handle_nxt = rd_q_r.symbol;
          state_nxt      = ST_DONE;
        end else if (cnt_r == LAST_IDX) begin
          res_status_nxt = (item_r.operation == OP_INSERT) ? STATUS_REFUSED
                                                           : STATUS_NOT_FOUND;
          state_nxt      = ST_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          cnt_nxt = cnt_r + IDX_W'(1);
          rd_en   = 1'b1;
          rd_addr = idx_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    item_r       <= item_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
  end

endmodule

@@ rtl/core/shtlp_guard.sv @@
// Summary registers of the table: letter filter, longest name and entry count.
// Gives the early find rejection and insert refusal. Depends on shtlp_pkg.
module shtlp_guard (
  input  logic            clk,
  input  logic            rst_n,
  input  shtlp_pkg::item_t chk_item,
  input  shtlp_pkg::item_t upd_item,
  input  logic            upd_en,
  output shtlp_pkg::guard_t guard
);
  import shtlp_pkg::*;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CASE_BIT = 8'h20;

  logic [31:0]      filter_r, filter_nxt;
  logic [15:0]      longest_r, longest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [5:0] letter_code(logic [7:0] c);
    logic [7:0] low;
    logic [7:0] diff;
    low  = c | CASE_BIT;
    diff = low - CHAR_A;
    return {(low >= CHAR_A) && (diff < 8'd32), diff[4:0]};
  endfunction

  logic [5:0] chk_code;
  logic [5:0] upd_code;

  assign chk_code = letter_code(chk_item.first_char);
  assign upd_code = letter_code(upd_item.first_char);

  always_comb begin
    guard.find_reject = (chk_code[5] && !filter_r[chk_code[4:0]]) ||
                        (chk_item.name_length > longest_r) ||
                        (chk_item.key_hash == 32'd0);
    guard.insert_refuse = (chk_item.key_hash == 32'd0) || (count_r >= CNT_W'(HALF));
  end

  always_comb begin
    filter_nxt  = filter_r;
    longest_nxt = longest_r;
    count_nxt   = count_r;
    if (upd_en) begin
      if (upd_code[5]) begin
        filter_nxt[upd_code[4:0]] = 1'b1;
      end
      if (upd_item.name_length > longest_r) begin
        longest_nxt = upd_item.name_length;
      end
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r  <= '0;
      longest_r <= '0;
      count_r   <= '0;
    end else begin
      filter_r  <= filter_nxt;
      longest_r <= longest_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

@@ rtl/core/shtlp_checker.sv @@
// Port-level checker of the symbol hash table, bound to the top level.
// Depends on shtlp_pkg and the top level symbol_hash_table_linear_probe.
module shtlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_found_handle
);
  import shtlp_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ports not quiet after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new word taken while an item is in work");

  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_FOUND |-> out_found_handle == 32'd0)
    else $error("nonzero handle on a result that is not a hit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_found_handle))
    else $error("stalled result word changed");

endmodule

bind symbol_hash_table_linear_probe shtlp_checker u_shtlp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_found_handle (out_ch.found_handle)
);

@@ test/symbol_hash_table_linear_probe_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the linear-probe symbol hash table.
// Depends on shtlp_pkg, shtlp_if and the top level symbol_hash_table_linear_probe.
// Directed and random find/insert words are checked against an in-bench table model.
module symbol_hash_table_linear_probe_test;
  import shtlp_pkg::*;

  localparam logic [31:0] CASE_BIT = 32'h20;
  localparam logic [31:0] LETTER_A = 32'h61;
  localparam int FILTER_BITS = 32;
  localparam int IDLE_PERCENT = 26;
  localparam int STEADY_FIRST = 220;
  localparam int STEADY_LAST = 360;
  localparam int PHASE_A_WORDS = 40;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_handle;
  } reply_t;

  typedef struct {
    item_t word;
    bit    settle;
  } backlog_t;

  typedef struct {
    logic [31:0] hash;
    logic [31:0] name;
    logic [7:0]  first_char;
    logic [15:0] name_length;
  } symbol_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  shtlp_in_if in_ch ();
  shtlp_out_if out_ch ();

  symbol_hash_table_linear_probe u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #6 clk = ~clk;

  bit [31:0] tbl_hash [SLOTS];
  bit [31:0] tbl_name [SLOTS];
  bit [31:0] tbl_symbol [SLOTS];
  bit [31:0] letter_mask;
  bit [15:0] longest_len;
  bit [CNT_W-1:0] used_slots;

  backlog_t request_backlog[$];
  reply_t due_replies[$];
  symbol_t known_symbols[$];
  item_t in_word;
  int unsigned words_queued;
  int unsigned words_accepted;
  int unsigned replies_seen;
  int unsigned mismatches;
  int unsigned inserts_queued;

  function automatic reply_t apply_symbol_op(item_t req);
    reply_t res;
    logic [31:0] letter;
    logic [IDX_W-1:0] idx;
    int n;
    bit rejected;
    res.status = STATUS_NOT_FOUND;
    res.found_handle = '0;
    letter = ({24'd0, req.first_char} | CASE_BIT) - LETTER_A;
    idx = req.key_hash[IDX_W-1:0];
    if (req.operation == OP_INSERT) begin
      if (req.key_hash == '0 || used_slots >= HALF) begin
        res.status = STATUS_REFUSED;
      end else begin
        n = 0;
        while (n < SLOTS && tbl_hash[idx] != '0) begin
          idx++;
          n++;
        end
        if (tbl_hash[idx] != '0) begin
          res.status = STATUS_REFUSED;
        end else begin
          if (letter < FILTER_BITS) letter_mask[letter[4:0]] = 1'b1;
          tbl_hash[idx] = req.key_hash;
          tbl_name[idx] = req.name_id;
          tbl_symbol[idx] = req.symbol_handle;
          if (req.name_length > longest_len) longest_len = req.name_length;
          used_slots++;
          res.status = STATUS_INSERTED;
        end
      end
    end else begin
      rejected = (letter < FILTER_BITS && !letter_mask[letter[4:0]]) ||
                 req.name_length > longest_len || req.key_hash == '0;
      if (!rejected) begin
        for (n = 0; n < SLOTS && tbl_hash[idx] != '0; n++) begin
          if (tbl_hash[idx] == req.key_hash && tbl_name[idx] == req.name_id) begin
            res.status = STATUS_FOUND;
            res.found_handle = tbl_symbol[idx];
            break;
          end
          idx++;
        end
      end
    end
    return res;
  endfunction

  function automatic bit side_idles(int unsigned count);
    if (count >= STEADY_FIRST && count < STEADY_LAST) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PERCENT;
  endfunction

  task automatic push_word(logic op, logic [31:0] hash, logic [31:0] name,
                           logic [7:0] fc, logic [15:0] len, logic [31:0] handle,
                           bit settle = 1'b0);
    backlog_t entry;
    symbol_t sym;
    entry.word.operation = op;
    entry.word.key_hash = hash;
    entry.word.name_id = name;
    entry.word.first_char = fc;
    entry.word.name_length = len;
    entry.word.symbol_handle = handle;
    entry.settle = settle;
    request_backlog.push_back(entry);
    words_queued++;
    if (op == OP_INSERT && hash != '0) begin
      sym.hash = hash;
      sym.name = name;
      sym.first_char = fc;
      sym.name_length = len;
      known_symbols.push_back(sym);
      inserts_queued++;
    end
  endtask

  function automatic logic [31:0] pick_hash();
    int unsigned r;
    logic [31:0] h;
    r = $urandom_range(0, 99);
    h = $urandom();
    if (r < 20) begin
      h[IDX_W-1:0] = IDX_W'((SLOTS - 4 + $urandom_range(0, 7)) % SLOTS);
    end else if (r < 25) begin
      h = $urandom_range(1, SLOTS - 1);
    end
    if (h == '0) h = 32'd1;
    return h;
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 70) begin
      c = 8'h61 + 8'($urandom_range(0, 12));
      if ($urandom_range(0, 1) == 1) c = c & ~8'h20;
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic random_insert();
    logic [31:0] h;
    h = ($urandom_range(0, 99) < 2) ? 32'd0 : pick_hash();
    push_word(OP_INSERT, h, $urandom(), pick_letter(), 16'($urandom_range(0, 40)),
              $urandom());
  endtask

  task automatic random_find(bit wide_len);
    int unsigned r;
    symbol_t sym;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (known_symbols.size() != 0 && r < 60) begin
      sym = known_symbols[$urandom_range(0, known_symbols.size() - 1)];
      if (r >= 45) sym.name = sym.name ^ (32'($urandom_range(1, 255)) << $urandom_range(0, 24));
      push_word(OP_FIND, sym.hash, sym.name, sym.first_char, sym.name_length, $urandom());
    end else if (r < 95) begin
      len = wide_len ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 48));
      push_word(OP_FIND, pick_hash(), $urandom(), 8'($urandom_range(0, 255)), len,
                $urandom());
    end else begin
      push_word(1'($urandom_range(0, 1)), $urandom(), $urandom(), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), $urandom());
    end
  endtask

  initial begin
    int i;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.key_hash = '0;
    in_ch.name_id = '0;
    in_ch.first_char = '0;
    in_ch.name_length = '0;
    in_ch.symbol_handle = '0;
    out_ch.ready = 1'b0;

    // Directed words: empty-table finds, zero hashes, collisions that wrap past the
    // last slot, duplicates, filter and length rejections.
    push_word(OP_FIND, 32'd1, 32'd0, "a", 16'd0, 32'd0);
    push_word(OP_FIND, 32'd5, 32'd7, 8'hFF, 16'd0, 32'hFFFFFFFF);
    push_word(OP_FIND, 32'd0, 32'd0, 8'hFF, 16'd0, 32'd0);
    push_word(OP_INSERT, 32'd0, 32'd3, "b", 16'd2, 32'hDEADBEEF);
    push_word(OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, "Z", 16'd5, 32'hFFFFFFFF);
    push_word(OP_INSERT, 32'h000003FF, 32'd0, "a", 16'd0, 32'd0);
    push_word(OP_INSERT, 32'h00000400, 32'h0BADF00D, 8'h00, 16'd3, 32'h12345678);
    push_word(OP_FIND, 32'h00000400, 32'h0BADF00D, 8'h00, 16'd3, 32'd0);
    push_word(OP_FIND, 32'h000003FF, 32'd0, "A", 16'd0, 32'hFFFFFFFF);
    push_word(OP_FIND, 32'hFFFFFFFF, 32'hFFFFFFFF, "z", 16'd5, 32'd0);
    push_word(OP_FIND, 32'hFFFFFFFF, 32'd1, "z", 16'd5, 32'd0);
    push_word(OP_FIND, 32'hFFFFFFFF, 32'hFFFFFFFF, "z", 16'd6, 32'd0);
    push_word(OP_FIND, 32'h00000400, 32'h0BADF00D, "q", 16'd3, 32'd0);
    push_word(OP_INSERT, 32'h00000400, 32'h0BADF00D, 8'h00, 16'd3, 32'hA5A5A5A5);
    push_word(OP_FIND, 32'h00000400, 32'h0BADF00D, 8'h40, 16'd1, 32'd0);
    push_word(OP_INSERT, 32'h00000C01, 32'h00000055, 8'h7F, 16'd4, 32'h5A5A5A5A);
    push_word(OP_FIND, 32'h00000C01, 32'h00000055, 8'h5F, 16'd4, 32'd0);
    push_word(OP_FIND, 32'h00000C01, 32'h00000055, 8'h80, 16'hFFFF, 32'd0);
    push_word(OP_FIND, 32'h00000C01, 32'h00000055, 8'h60, 16'd0, 32'd0);

    for (i = 0; i < PHASE_A_WORDS; i++) begin
      if ($urandom_range(0, 1) == 1) random_insert();
      else random_find(1'b1);
    end

    // The longest name goes in only after the length filter has had its use.
    push_word(OP_INSERT, pick_hash(), $urandom(), pick_letter(), 16'hFFFF, $urandom(), 1'b1);
    while (inserts_queued < HALF + 4) begin
      if ($urandom_range(0, 99) < 97) random_insert();
      else random_find(1'b1);
    end
    for (i = 0; i < 16; i++) random_find(1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted != words_queued || due_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** symbol_hash_table_linear_probe: PASSED **");
    end else begin
      $display("** symbol_hash_table_linear_probe: FAILED **");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("** symbol_hash_table_linear_probe: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    backlog_t head;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_replies.push_back(apply_symbol_op(in_word));
        words_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (request_backlog.size() != 0 &&
            !(request_backlog[0].settle && due_replies.size() != 0) &&
            !side_idles(words_accepted)) begin
          head = request_backlog.pop_front();
          in_word = head.word;
          in_ch.valid <= 1'b1;
          in_ch.operation <= head.word.operation;
          in_ch.key_hash <= head.word.key_hash;
          in_ch.name_id <= head.word.name_id;
          in_ch.first_char <= head.word.first_char;
          in_ch.name_length <= head.word.name_length;
          in_ch.symbol_handle <= head.word.symbol_handle;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        replies_seen++;
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result word: status %0d handle %h",
                     out_ch.status, out_ch.found_handle);
          end
        end else begin
          want = due_replies.pop_front();
          if (out_ch.status !== want.status || out_ch.found_handle !== want.found_handle) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result word %0d: expected status %0d handle %h, got status %0d handle %h",
                       replies_seen, want.status, want.found_handle,
                       out_ch.status, out_ch.found_handle);
            end
          end
        end
      end
      out_ch.ready <= !side_idles(replies_seen);
    end
  end

endmodule

@@ symbol_hash_table_linear_probe.f @@
rtl/core/shtlp_pkg.sv
rtl/core/shtlp_if.sv
rtl/core/shtlp_guard.sv
rtl/core/symbol_hash_table_linear_probe.sv
rtl/core/shtlp_checker.sv
test/symbol_hash_table_linear_probe_test.sv
